// ===== design/wrps_pkg.sv =====
package wrps_pkg;

    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_PICK   = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    localparam int TOTAL_W = 30;
    localparam logic [TOTAL_W-1:0] TOTAL_LIMIT = 30'h3FFFFFFF;

    typedef struct packed {
        logic        start;
        logic [30:0] dividend;
        logic [29:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [30:0] quotient;
        logic [29:0] remainder;
    } t_div_rsp;

endpackage

// ===== design/wrps_ram.sv =====
module wrps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== design/wrps_div.sv =====
module wrps_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wrps_pkg::t_div_req i_req,
    output wrps_pkg::t_div_rsp o_rsp
);

    logic [30:0] r_quot;
    logic [30:0] n_quot;
    logic [30:0] r_rem;
    logic [30:0] n_rem;
    logic [29:0] r_dvs;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [31:0] trial;

    assign trial = {r_rem, r_quot[30]} - {2'b00, r_dvs};

    always_comb begin
        n_quot = {r_quot[29:0], 1'b0};
        n_rem  = {r_rem[29:0], r_quot[30]};
        if (!trial[31]) begin
            n_rem     = trial[30:0];
            n_quot[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
                r_quot <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_quot <= n_quot;
                r_rem  <= n_rem;
                r_cnt  <= r_cnt + 5'd1;
                if (r_cnt == 5'd30) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quot;
    assign o_rsp.remainder = r_rem[29:0];

endmodule

// ===== design/weighted_rect_point_sampler.sv =====
// Weighted rectangle point sampler. Raise start with a command while busy is low;
// exactly one result appears with o_valid high for one cycle and the receiver cannot
// stall it. A clear or append holds busy high only while it is checked, and its result follows on
// the next cycle. A pick holds busy high through the modulo of the random word by the total
// on the shared restoring divider, a binary search over the prefix-sum memory (at most
// log2 of the table size steps, rounded up), the read of the previous prefix sum and the
// division of the offset by the column count on the same divider, with the result on the
// following cycle.
module weighted_rect_point_sampler #(
    parameter int MAX_RECTS = 128,
    parameter int MAX_SIDE  = 2048
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_func,
    input  logic signed [31:0] i_corner_x_low,
    input  logic signed [31:0] i_corner_y_low,
    input  logic signed [31:0] i_corner_x_high,
    input  logic signed [31:0] i_corner_y_high,
    input  logic [30:0]        i_random_word,
    output logic               o_valid,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic [1:0]         o_status
);

    localparam int AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CW = $clog2(MAX_RECTS + 1);
    localparam int SW = $clog2(MAX_SIDE + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_MOD    = 4'd2;
    localparam logic [3:0] S_SRCH   = 4'd3;
    localparam logic [3:0] S_SWAIT  = 4'd4;
    localparam logic [3:0] S_PREV   = 4'd5;
    localparam logic [3:0] S_PWAIT  = 4'd6;
    localparam logic [3:0] S_DIV    = 4'd7;
    localparam logic [3:0] S_DWAIT  = 4'd8;
    localparam logic [3:0] S_MODW   = 4'd9;
    localparam logic [3:0] S_SREAD  = 4'd10;

    logic [3:0]  r_state;
    logic [CW-1:0] r_count;
    logic [29:0] r_total;
    logic [1:0]  r_func;
    logic signed [32:0] r_cols;
    logic signed [32:0] r_rows;
    logic [31:0] r_xl;
    logic [31:0] r_yl;
    logic [30:0] r_word;
    logic [29:0] r_idx;
    logic [AW-1:0] r_lo;
    logic [AW-1:0] r_hi;
    logic [AW-1:0] r_raddr;
    logic [29:0] r_start;

    logic [31:0] q_lx;
    logic [31:0] q_by;
    logic [SW-1:0] q_cols;
    logic [29:0] q_pref;

    logic        we;
    logic [2*SW-1:0] area;
    logic [30:0] sum;
    logic [AW-1:0] mid;
    logic [29:0] offset;
    logic [29:0] div_cols;

    wrps_pkg::t_div_req div_req;
    wrps_pkg::t_div_rsp div_rsp;

    assign area = r_cols[SW-1:0] * r_rows[SW-1:0];
    assign sum  = {1'b0, r_total} + 31'(area);
    assign mid  = r_lo + ((r_hi - r_lo) >> 1);
    assign offset = r_idx - r_start;
    assign div_cols = (q_cols == '0) ? 30'd1 : 30'(q_cols);
    assign we = (r_state == S_CHECK) && (r_func == wrps_pkg::FUNC_APPEND)
        && (r_count < CW'(MAX_RECTS)) && (r_cols > 33'sd0) && (r_rows > 33'sd0)
        && (r_cols <= 33'(MAX_SIDE)) && (r_rows <= 33'(MAX_SIDE))
        && (sum <= {1'b0, wrps_pkg::TOTAL_LIMIT});

    wrps_ram #(.WIDTH(32), .DEPTH(MAX_RECTS)) u_lx (.i_clk, .i_we(we),
        .i_waddr(r_count[AW-1:0]), .i_wdata(r_xl), .i_raddr(r_raddr), .o_rdata(q_lx));
    wrps_ram #(.WIDTH(32), .DEPTH(MAX_RECTS)) u_by (.i_clk, .i_we(we),
        .i_waddr(r_count[AW-1:0]), .i_wdata(r_yl), .i_raddr(r_raddr), .o_rdata(q_by));
    wrps_ram #(.WIDTH(SW), .DEPTH(MAX_RECTS)) u_cl (.i_clk, .i_we(we),
        .i_waddr(r_count[AW-1:0]), .i_wdata(r_cols[SW-1:0]), .i_raddr(r_raddr),
        .o_rdata(q_cols));
    wrps_ram #(.WIDTH(30), .DEPTH(MAX_RECTS)) u_pt (.i_clk, .i_we(we),
        .i_waddr(r_count[AW-1:0]), .i_wdata(sum[29:0]), .i_raddr(r_raddr),
        .o_rdata(q_pref));

    wrps_div u_div (.i_clk, .i_rst_n, .i_req(div_req), .o_rsp(div_rsp));

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = r_word;
        div_req.divisor  = r_total;
        if (r_state == S_MOD) begin
            div_req.start = 1'b1;
        end else if (r_state == S_DIV) begin
            div_req.start    = 1'b1;
            div_req.dividend = {1'b0, offset};
            div_req.divisor  = div_cols;
        end
    end

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_total <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_func  <= i_func;
                        r_xl    <= i_corner_x_low;
                        r_yl    <= i_corner_y_low;
                        r_cols  <= {i_corner_x_high[31], i_corner_x_high}
                            - {i_corner_x_low[31], i_corner_x_low} + 33'sd1;
                        r_rows  <= {i_corner_y_high[31], i_corner_y_high}
                            - {i_corner_y_low[31], i_corner_y_low} + 33'sd1;
                        r_word  <= i_random_word;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    o_point_x <= '0;
                    o_point_y <= '0;
                    o_status  <= wrps_pkg::ST_OK;
                    r_state   <= S_IDLE;
                    case (r_func)
                        wrps_pkg::FUNC_CLEAR: begin
                            r_count <= '0;
                            r_total <= '0;
                            o_valid <= 1'b1;
                        end
                        wrps_pkg::FUNC_APPEND: begin
                            o_valid <= 1'b1;
                            if (r_count >= CW'(MAX_RECTS)) begin
                                o_status <= wrps_pkg::ST_FULL;
                            end else if (!we) begin
                                o_status <= wrps_pkg::ST_BAD;
                            end else begin
                                r_count <= r_count + CW'(1);
                                r_total <= sum[29:0];
                            end
                        end
                        wrps_pkg::FUNC_PICK: begin
                            if (r_count == '0 || r_total == '0) begin
                                o_status <= wrps_pkg::ST_EMPTY;
                                o_valid  <= 1'b1;
                            end else begin
                                r_state <= S_MOD;
                            end
                        end
                        default: begin
                            o_valid <= 1'b1;
                        end
                    endcase
                end
                S_MOD: begin
                    r_lo    <= '0;
                    r_hi    <= AW'(r_count - CW'(1));
                    r_state <= S_MODW;
                end
                S_MODW: begin
                    if (div_rsp.done) begin
                        r_idx   <= div_rsp.remainder;
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (r_lo < r_hi) begin
                        r_raddr <= mid;
                        r_state <= S_SREAD;
                    end else begin
                        r_raddr <= r_lo - AW'(1);
                        r_state <= S_PREV;
                    end
                end
                S_SREAD: begin
                    r_state <= S_SWAIT;
                end
                S_SWAIT: begin
                    if (q_pref <= r_idx) begin
                        r_lo <= r_raddr + AW'(1);
                    end else begin
                        r_hi <= r_raddr;
                    end
                    r_state <= S_SRCH;
                end
                S_PREV: begin
                    r_raddr <= r_lo;
                    r_state <= S_PWAIT;
                end
                S_PWAIT: begin
                    r_start <= (r_lo == '0) ? '0 : q_pref;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (div_rsp.done) begin
                        o_point_x <= q_lx + {2'b00, div_rsp.remainder};
                        o_point_y <= q_by + {1'b0, div_rsp.quotient};
                        o_status  <= wrps_pkg::ST_OK;
                        o_valid   <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int NUM_RECTS  = 128;
    localparam int SIDE_LIMIT = 2048;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic [1:0]  func;
        logic [31:0] xl, yl, xh, yh;
        logic [30:0] word;
    } t_cmd;

    typedef struct {
        logic [31:0] px, py;
        logic [1:0]  st;
    } t_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_func = '0;
    logic signed [31:0] i_corner_x_low = '0, i_corner_y_low = '0;
    logic signed [31:0] i_corner_x_high = '0, i_corner_y_high = '0;
    logic [30:0] i_random_word = '0;
    logic        o_valid;
    logic signed [31:0] o_point_x, o_point_y;
    logic [1:0]  o_status;

    weighted_rect_point_sampler dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_cmd pending_cmds[$];
    t_res expected_points[$];
    logic [31:0] tbl_x[NUM_RECTS], tbl_y[NUM_RECTS];
    logic [31:0] tbl_cols[NUM_RECTS], tbl_prefix[NUM_RECTS];
    int unsigned tbl_count = 0;
    logic [31:0] tbl_total = 0;
    int errors = 0;
    int idle_cycles = 0;
    bit feed_done = 0;
    bit in_taken = 0;
    int gap = 0;

    function automatic void add_cmd(t_cmd c);
        pending_cmds.insert(pending_cmds.size(), c);
    endfunction

    function automatic t_res sample_point(t_cmd c);
        t_res r;
        longint xl, yl, xh, yh, cols, rows, sum;
        int unsigned lo, hi, mid;
        logic [31:0] idx, off, base;
        r.px = 0; r.py = 0; r.st = wrps_pkg::ST_OK;
        if (c.func == wrps_pkg::FUNC_CLEAR) begin
            tbl_count = 0; tbl_total = 0;
        end else if (c.func == wrps_pkg::FUNC_APPEND) begin
            xl = $signed(c.xl); yl = $signed(c.yl);
            xh = $signed(c.xh); yh = $signed(c.yh);
            cols = xh - xl + 1; rows = yh - yl + 1;
            sum = longint'(tbl_total) + cols * rows;
            if (tbl_count >= NUM_RECTS) r.st = wrps_pkg::ST_FULL;
            else if (xh < xl || yh < yl) r.st = wrps_pkg::ST_BAD;
            else if (cols > SIDE_LIMIT || rows > SIDE_LIMIT) r.st = wrps_pkg::ST_BAD;
            else if (sum > longint'(wrps_pkg::TOTAL_LIMIT)) r.st = wrps_pkg::ST_BAD;
            else begin
                tbl_x[tbl_count] = c.xl; tbl_y[tbl_count] = c.yl;
                tbl_cols[tbl_count] = cols[31:0];
                tbl_prefix[tbl_count] = sum[31:0];
                tbl_total = sum[31:0];
                tbl_count++;
            end
        end else if (c.func == wrps_pkg::FUNC_PICK) begin
            if (tbl_count == 0 || tbl_total == 0) r.st = wrps_pkg::ST_EMPTY;
            else begin
                idx = {1'b0, c.word} % tbl_total;
                lo = 0; hi = tbl_count - 1;
                while (lo < hi) begin
                    mid = lo + (hi - lo) / 2;
                    if (tbl_prefix[mid] <= idx) lo = mid + 1;
                    else hi = mid;
                end
                base = (lo == 0) ? 0 : tbl_prefix[lo-1];
                off = idx - base;
                r.px = tbl_x[lo] + off % tbl_cols[lo];
                r.py = tbl_y[lo] + off / tbl_cols[lo];
            end
        end
        return r;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 150);
        return $urandom_range(0, 4);
    endfunction

    function automatic t_cmd rect_cmd(int w, int h, logic [31:0] x, logic [31:0] y);
        t_cmd c;
        c.func = wrps_pkg::FUNC_APPEND; c.xl = x; c.yl = y;
        c.xh = x + w - 1; c.yh = y + h - 1; c.word = 31'($urandom());
        return c;
    endfunction

    function automatic t_cmd op_cmd(logic [1:0] f, logic [30:0] w);
        t_cmd c;
        c.func = f; c.word = w;
        c.xl = $urandom(); c.yl = $urandom(); c.xh = $urandom(); c.yh = $urandom();
        return c;
    endfunction

    always @(negedge i_clk) begin
        t_cmd c;
        if (i_rst_n) begin
            if (!start || in_taken) begin
                if (gap > 0) begin
                    gap <= gap - 1;
                    start <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    c = pending_cmds.pop_front();
                    start <= 1'b1;
                    i_func <= c.func;
                    i_corner_x_low <= c.xl; i_corner_y_low <= c.yl;
                    i_corner_x_high <= c.xh; i_corner_y_high <= c.yh;
                    i_random_word <= c.word;
                    gap <= pick_gap();
                end else begin
                    start <= 1'b0;
                    feed_done <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_cmd c;
        t_res e;
        if (i_rst_n) begin
            in_taken <= start && !busy;
            if ((start && !busy) || o_valid) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (start && !busy) begin
                c.func = i_func; c.xl = i_corner_x_low; c.yl = i_corner_y_low;
                c.xh = i_corner_x_high; c.yh = i_corner_y_high; c.word = i_random_word;
                expected_points.insert(expected_points.size(), sample_point(c));
            end
            if (o_valid) begin
                if (expected_points.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected item: %h %h %0d",
                                               o_point_x, o_point_y, o_status);
                end else begin
                    e = expected_points.pop_front();
                    if (e.px !== o_point_x || e.py !== o_point_y || e.st !== o_status) begin
                        errors++;
                        if (errors <= 10)
                            $display("exp %h %h %0d got %h %h %0d", e.px, e.py, e.st,
                                     o_point_x, o_point_y, o_status);
                    end
                end
            end
            if (idle_cycles > STALL_LIMIT) begin
                $display("weighted_rect_point_sampler: mismatch");
                $finish;
            end
        end
    end

    initial begin
        int n, kind, w, h;
        logic [31:0] x, y;
        add_cmd(op_cmd(wrps_pkg::FUNC_PICK, 31'h7FFFFFFF));
        add_cmd(op_cmd(wrps_pkg::FUNC_UNUSED, 31'd5));
        add_cmd(rect_cmd(1, 1, 32'h80000000, 32'h7FFFFFFF));
        add_cmd(op_cmd(wrps_pkg::FUNC_PICK, 31'h7FFFFFFF));
        add_cmd(rect_cmd(2048, 2048, 32'h7FFFF801, 32'h80000000));
        add_cmd(rect_cmd(2049, 1, 0, 0));
        add_cmd(rect_cmd(1, 2049, 0, 0));
        add_cmd(rect_cmd(0, 1, 5, 5));
        add_cmd(rect_cmd(1, 0, 5, 5));
        add_cmd(rect_cmd(1, 1, 32'h7FFFFFFF, 32'h80000000));
        add_cmd(op_cmd(wrps_pkg::FUNC_PICK, 31'd0));
        add_cmd(op_cmd(wrps_pkg::FUNC_PICK, 31'h40000000));
        add_cmd(op_cmd(wrps_pkg::FUNC_CLEAR, 31'd0));
        for (int i = 0; i < 255; i++) add_cmd(rect_cmd(2048, 2048, i, 0));
        add_cmd(rect_cmd(3, 2, 0, 0));
        add_cmd(op_cmd(wrps_pkg::FUNC_PICK, 31'h7FFFFFFF));
        add_cmd(op_cmd(wrps_pkg::FUNC_CLEAR, 31'd0));
        for (int i = 0; i < 130; i++) add_cmd(rect_cmd(1, 2, i * 4, -i));
        add_cmd(op_cmd(wrps_pkg::FUNC_PICK, 31'h12345));
        add_cmd(op_cmd(wrps_pkg::FUNC_PICK, 31'h7FFFFFFE));
        n = pending_cmds.size();
        while (n < 1950) begin
            add_cmd(op_cmd(wrps_pkg::FUNC_CLEAR, 31'd0));
            n++;
            x = $urandom(); y = $urandom();
            for (int r = $urandom_range(1, 40); r > 0; r--) begin
                kind = $urandom_range(0, 19);
                if (kind == 0) begin w = $urandom_range(1, 2048); h = $urandom_range(1, 2048); end
                else if (kind == 1) begin w = $urandom_range(0, 3000); h = $urandom_range(0, 3000); end
                else begin w = $urandom_range(1, 40); h = $urandom_range(1, 40); end
                add_cmd(rect_cmd(w, h, x, y));
                x = x + 3000;
                n++;
                if ($urandom_range(0, 3) == 0) begin
                    add_cmd(op_cmd(wrps_pkg::FUNC_PICK, 31'($urandom()))); n++;
                end
            end
            if ($urandom_range(0, 9) == 0) begin
                add_cmd(op_cmd(wrps_pkg::FUNC_APPEND, 31'($urandom()))); n++;
            end
            for (int p = $urandom_range(2, 30); p > 0; p--) begin
                add_cmd(op_cmd($urandom_range(0, 19) == 0 ? wrps_pkg::FUNC_UNUSED
                                                          : wrps_pkg::FUNC_PICK,
                               31'($urandom())));
                n++;
            end
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;
        wait (feed_done);
        while (expected_points.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && expected_points.size() == 0)
            $display("weighted_rect_point_sampler: match");
        else
            $display("weighted_rect_point_sampler: mismatch");
        $finish;
    end
endmodule
